FILE: rtl/core/fed_pkg.sv
// ----------------------------------------------------------------------------
// fed_pkg
// Shared widths, register codes, reset values and control types for the
// feedback echo delay.
// ----------------------------------------------------------------------------
package fed_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int DELAY_W    = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int RING_DEPTH_DEF = 32768;

    localparam logic [GAIN_W-1:0]  GAIN_ONE    = 16'd32768;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd16384;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 15'd22050;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE = 2'd0,
        CFG_DELAY  = 2'd1,
        CFG_GAIN   = 2'd2
    } cfg_idx_t;

    // settings seen by the sample pipeline
    typedef struct packed {
        logic              enable;
        logic [GAIN_W-1:0] gain;
        logic              busy;
    } cfg_t;

endpackage

FILE: rtl/core/fed_ram.sv
// ----------------------------------------------------------------------------
// fed_ram
// Generic simple dual-port RAM, one write and one read port, registered
// read data (read-first on an address clash).
// ----------------------------------------------------------------------------
module fed_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/fed_cfg.sv
// ----------------------------------------------------------------------------
// fed_cfg
// Configuration registers. The delay is reduced modulo the ring depth by a
// three-step reciprocal unit after each delay write; busy holds off items.
// ----------------------------------------------------------------------------
module fed_cfg #(
    parameter int RING_DEPTH = fed_pkg::RING_DEPTH_DEF,
    parameter int AW         = $clog2(RING_DEPTH)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [fed_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [fed_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output fed_pkg::cfg_t                   cfg,
    output logic [AW-1:0]                   dmod
);
    import fed_pkg::*;

    localparam int RSHIFT = 31;
    localparam logic [RSHIFT-1:0] RECIP = RSHIFT'((64'd1 << RSHIFT) / RING_DEPTH);
    localparam logic [AW-1:0] DMOD_RESET = AW'(int'(DELAY_RESET) % RING_DEPTH);
    localparam logic [16:0] DEPTH_C = 17'(RING_DEPTH);

    logic              enable_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [AW-1:0]     dmod_reg;
    logic              st1_reg;
    logic              st2_reg;
    logic [DELAY_W-1:0] d_reg;
    logic [DELAY_W-1:0] q_reg;
    logic [DELAY_W-1:0] rraw_reg;

    logic                     delay_wr;
    logic [DELAY_W-1:0]       d_in;
    logic [DELAY_W+RSHIFT-1:0] qprod;
    logic [31:0]              qn;
    logic [16:0]              rraw_ext;
    logic [16:0]              rfix;

    assign d_in     = cfg_wdata[DELAY_W-1:0];
    assign delay_wr = cfg_wr_en && (cfg_addr == CFG_DELAY);
    assign qprod    = (DELAY_W+RSHIFT)'(d_in) * (DELAY_W+RSHIFT)'(RECIP);
    assign qn       = 32'(q_reg) * 32'(RING_DEPTH);
    assign rraw_ext = 17'(rraw_reg);
    // estimate is at most one short: one subtract corrects it
    assign rfix     = (rraw_ext >= DEPTH_C) ? rraw_ext - DEPTH_C : rraw_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            gain_reg   <= GAIN_RESET;
            dmod_reg   <= DMOD_RESET;
            st1_reg    <= 1'b0;
            st2_reg    <= 1'b0;
        end
        else
        begin
            st1_reg <= delay_wr;
            st2_reg <= st1_reg;
            if (st2_reg)
            begin
                dmod_reg <= AW'(rfix);
            end
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    CFG_ENABLE: enable_reg <= cfg_wdata[0];
                    CFG_GAIN:   gain_reg   <= (cfg_wdata > GAIN_ONE) ? GAIN_ONE : cfg_wdata;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (delay_wr)
        begin
            d_reg <= d_in;
            q_reg <= qprod[DELAY_W+RSHIFT-1:RSHIFT];
        end
        if (st1_reg)
        begin
            rraw_reg <= d_reg - qn[DELAY_W-1:0];
        end
    end

    assign cfg.enable = enable_reg;
    assign cfg.gain   = gain_reg;
    assign cfg.busy   = st1_reg || st2_reg;
    assign dmod       = dmod_reg;

    a_dmod_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, dmod_reg} < (AW+1)'(RING_DEPTH)))
        else $error("reduced delay not below ring depth");

    a_unit_one_shot: assert property (@(posedge clk) disable iff (!rst_n)
        st1_reg |=> st2_reg)
        else $error("delay reduction step lost");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        st2_reg |-> !st1_reg || $past(delay_wr))
        else $error("delay reduction steps out of order");

endmodule

FILE: rtl/core/fed_core.sv
// ----------------------------------------------------------------------------
// fed_core
// Sample pipeline: tap read, gain multiply, sum and ring write-back, output
// register. Interlocks a tap read against ring writes still in flight.
// ----------------------------------------------------------------------------
module fed_core #(
    parameter int RING_DEPTH = fed_pkg::RING_DEPTH_DEF,
    parameter int AW         = $clog2(RING_DEPTH)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fed_pkg::cfg_t                       cfg,
    input  logic [AW-1:0]                       dmod,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [fed_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [fed_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                overflow,
    output logic                                ram_we,
    output logic [AW-1:0]                       ram_waddr,
    output logic [fed_pkg::SAMPLE_W-1:0]        ram_wdata,
    output logic                                ram_re,
    output logic [AW-1:0]                       ram_raddr,
    input  logic [fed_pkg::SAMPLE_W-1:0]        ram_rdata
);
    import fed_pkg::*;

    localparam logic [AW-1:0] LAST_POS = AW'(RING_DEPTH - 1);
    localparam int PW = 2 * SAMPLE_W + 1;

    logic [AW-1:0] pos_reg;
    logic          wrapped_reg;

    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_x_reg;
    logic [AW-1:0]              s1_pos_reg;
    logic                       s1_en_reg;
    logic                       s1_self_reg;
    logic                       s1_hit_reg;

    logic                       s2_valid_reg;
    logic signed [SAMPLE_W-1:0] s2_x_reg;
    logic [AW-1:0]              s2_pos_reg;
    logic                       s2_en_reg;
    logic signed [PW-1:0]       s2_prod_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_ovf_reg;

    logic                       out_free;
    logic                       s2_free;
    logic                       s2_adv;
    logic                       s1_free;
    logic                       s1_adv;
    logic                       hazard;
    logic                       accept;
    logic [AW:0]                diff;
    logic [AW-1:0]              tap;
    logic signed [SAMPLE_W-1:0] prev;
    logic signed [SAMPLE_W:0]   gain_s;
    logic signed [PW-1:0]       prod;
    logic signed [PW-1:0]       biased;
    logic signed [SAMPLE_W+1:0] scaled;
    logic signed [SAMPLE_W+1:0] sum;
    logic                       in_range;
    logic signed [SAMPLE_W-1:0] y;
    logic                       ovf;

    // tap address, wrapped into the ring
    assign diff = {1'b0, pos_reg} - {1'b0, dmod};
    assign tap  = diff[AW] ? AW'(diff + (AW+1)'(RING_DEPTH)) : diff[AW-1:0];

    assign out_free = !out_valid_reg || !out_stall;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;

    // hold while the tap entry is still on its way to the ring
    assign hazard = cfg.enable &&
                    ((s1_valid_reg && (s1_pos_reg == tap)) ||
                     (s2_valid_reg && (s2_pos_reg == tap)));

    assign in_stall = !s1_free || hazard || cfg.busy;
    assign accept   = in_valid && !in_stall;

    assign ram_re    = accept;
    assign ram_raddr = tap;

    // stage 1: select the tap and scale by the gain
    always_comb
    begin
        if (s1_self_reg)
        begin
            prev = s1_x_reg;
        end
        else if (s1_hit_reg)
        begin
            prev = signed'(ram_rdata);
        end
        else
        begin
            prev = '0;
        end
    end

    assign gain_s = signed'({1'b0, cfg.gain});
    assign prod   = prev * gain_s;

    // stage 2: truncate toward zero, add, detect wrap
    assign biased   = s2_prod_reg + (s2_prod_reg[PW-1] ? PW'(32767) : PW'(0));
    assign scaled   = signed'(biased[PW-1:SAMPLE_W-1]);
    assign sum      = {{2{s2_x_reg[SAMPLE_W-1]}}, s2_x_reg} + scaled;
    assign in_range = (sum[SAMPLE_W+1] == sum[SAMPLE_W-1]) &&
                      (sum[SAMPLE_W] == sum[SAMPLE_W-1]);
    assign y        = s2_en_reg ? sum[SAMPLE_W-1:0] : s2_x_reg;
    assign ovf      = s2_en_reg && !in_range;

    assign ram_we    = s2_adv;
    assign ram_waddr = s2_pos_reg;
    assign ram_wdata = y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            wrapped_reg   <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (pos_reg == LAST_POS)
                begin
                    pos_reg     <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            if (s1_free)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_adv;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_adv;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg    <= sample_in;
            s1_pos_reg  <= pos_reg;
            s1_en_reg   <= cfg.enable;
            s1_self_reg <= (dmod == '0);
            s1_hit_reg  <= wrapped_reg || (tap < pos_reg);
        end
        if (s1_adv)
        begin
            s2_x_reg    <= s1_x_reg;
            s2_pos_reg  <= s1_pos_reg;
            s2_en_reg   <= s1_en_reg;
            s2_prod_reg <= prod;
        end
        if (s2_adv)
        begin
            out_sample_reg <= y;
            out_ovf_reg    <= ovf;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = out_sample_reg;
    assign overflow   = out_ovf_reg;

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re && s1_en_reg) |-> (ram_waddr != ram_raddr) || (dmod == '0))
        else $error("tap read collides with ring write");

    a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_free) |-> !ram_re)
        else $error("tap data overwritten while stage 1 holds");

    a_distinct_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg) |-> (s1_pos_reg != s2_pos_reg))
        else $error("two items in flight share a ring entry");

    a_hit_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cfg.enable && s2_valid_reg) |-> (tap != s2_pos_reg))
        else $error("tap read of an unwritten entry");

endmodule

FILE: rtl/core/feedback_echo_delay.sv
// ----------------------------------------------------------------------------
// feedback_echo_delay
// Feedback comb echo: y = x + trunc(g * y[n-D]) over a ring of past outputs.
//
//   channel   direction  handshake             payload
//   input     in         in_valid / in_stall   sample_in
//   output    out        out_valid / out_stall sample_out, overflow
//   config    in         cfg_wr_en             cfg_addr, cfg_wdata
//
// One item per cycle when no stall holds it off; each item passes stage 1,
// stage 2 and the output register. A delay of one or two samples stalls on
// the ring read-after-write; a delay write holds off items until it is reduced.
// No clearing pass after reset: entries not yet written read as zero.
// Output stall backs up through the three pipeline stages to in_stall.
// ----------------------------------------------------------------------------
module feedback_echo_delay #(
    parameter int RING_DEPTH = fed_pkg::RING_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [fed_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [fed_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [fed_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [fed_pkg::SAMPLE_W-1:0] sample_out,
    output logic                                overflow
);
    import fed_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    cfg_t                cfg;
    logic [AW-1:0]       dmod;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    fed_cfg #(
        .RING_DEPTH (RING_DEPTH),
        .AW         (AW)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .dmod      (dmod)
    );

    fed_core #(
        .RING_DEPTH (RING_DEPTH),
        .AW         (AW)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .dmod       (dmod),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .overflow   (overflow),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    fed_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

FILE: test/feedback_echo_delay_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feedback_echo_delay_test
// Self-checking bench for the feedback echo delay. Samples are fed from a
// queue through a clocked driver, and each accepted item is run through a
// local comb filter model. Each output item is compared with the oldest
// prediction. Register settings change between phases, only once the block
// has drained. Both sides idle in random bursts, and the receiver holds off
// once for a long stretch.
// ----------------------------------------------------------------------------
module feedback_echo_delay_test;

    import fed_pkg::*;

    localparam int RING_DEPTH  = RING_DEPTH_DEF;
    localparam int SAMPLE_MAX  = 32767;
    localparam int SAMPLE_MIN  = -32768;
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_AFTER  = 400;
    localparam int HOLD_CYCLES = 300;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       ovf;
    } echo_result_t;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]        cfg_wdata = '0;
    logic                         in_valid  = 1'b0;
    logic                         in_stall;
    logic signed [SAMPLE_W-1:0]   sample_in = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]   sample_out;
    logic                         overflow;

    // echo model state
    logic signed [SAMPLE_W-1:0]   echo_hist [RING_DEPTH];
    int unsigned                  hist_pos;
    logic                         mdl_enable;
    logic [DELAY_W-1:0]           mdl_delay;
    logic [GAIN_W-1:0]            mdl_gain;

    logic [SAMPLE_W-1:0]          pending_samples [$];
    echo_result_t                 echo_expected [$];

    int   queued_count = 0;
    int   in_count     = 0;
    int   out_count    = 0;
    int   fail_count   = 0;
    int   idle_pct     = 0;
    int   send_gap     = 0;
    int   recv_gap     = 0;
    int   hold_left    = 0;
    bit   hold_done    = 1'b0;
    bit   item_taken   = 1'b0;

    feedback_echo_delay dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .overflow   (overflow)
    );

    always #5 clk = ~clk;

    // y = x + trunc(g * y[n-D]), written back to the history ring
    function automatic echo_result_t echo_next(input logic signed [SAMPLE_W-1:0] x);
        echo_result_t               r;
        int unsigned                d;
        int unsigned                tap;
        int unsigned                g;
        logic signed [SAMPLE_W-1:0] prev;
        longint                     prod;
        longint                     scaled;
        longint                     total;
        r.sample = x;
        r.ovf    = 1'b0;
        if (mdl_enable) begin
            d      = mdl_delay % RING_DEPTH;
            tap    = (hist_pos + RING_DEPTH - d) % RING_DEPTH;
            prev   = (d == 0) ? x : echo_hist[tap];
            g      = (mdl_gain > GAIN_ONE) ? GAIN_ONE : mdl_gain;
            prod   = longint'(prev) * longint'(g);
            // truncate toward zero
            scaled = (prod < 0) ? -((-prod) >>> 15) : (prod >>> 15);
            total  = longint'(x) + scaled;
            r.ovf    = (total > SAMPLE_MAX) || (total < SAMPLE_MIN);
            r.sample = total[SAMPLE_W-1:0];
        end
        echo_hist[hist_pos] = r.sample;
        hist_pos = (hist_pos + 1) % RING_DEPTH;
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            1:       return ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hFFFF;
            2, 3:    return SAMPLE_W'($urandom_range(0, 511) - 256);
            default: return SAMPLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic queue_sample(input logic [SAMPLE_W-1:0] s);
        pending_samples.push_back(s);
        queued_count++;
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            CFG_ENABLE: mdl_enable = data[0];
            CFG_DELAY:  mdl_delay  = data[DELAY_W-1:0];
            CFG_GAIN:   mdl_gain   = data;
            default:    ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait until every item is in and every result is out, then let the pipe empty
    task automatic settle();
        while (in_count != queued_count || echo_expected.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // sender: hold the item until taken, idle in bursts
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || item_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_samples.size() != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                send_gap = $urandom_range(1, 18) - 1;
                in_valid <= 1'b0;
            end
            else if (pending_samples.size() != 0)
            begin
                in_valid  <= 1'b1;
                sample_in <= pending_samples.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall bursts
    always @(negedge clk)
    begin
        if (recv_gap != 0)
            recv_gap--;
        else if ($urandom_range(0, 99) < idle_pct)
            recv_gap = $urandom_range(1, 18);
        out_stall <= (recv_gap != 0) || (hold_left != 0);
    end

    // long receiver hold-off, once, to back the block up to its input
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left--;
        else if (!hold_done && in_count >= HOLD_AFTER)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        echo_result_t want;
        item_taken = rst_n && in_valid && !in_stall;
        if (item_taken)
        begin
            echo_expected.push_back(echo_next(sample_in));
            in_count++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (echo_expected.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected output item: sample %0d overflow %b",
                             sample_out, overflow);
            end
            else
            begin
                want = echo_expected.pop_front();
                if (sample_out !== want.sample || overflow !== want.ovf)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("output %0d: expected sample %0d overflow %b, got sample %0d overflow %b",
                                 out_count, want.sample, want.ovf, sample_out, overflow);
                end
            end
            out_count++;
        end
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int                    ph;
        int                    n_items;
        logic [CFG_DATA_W-1:0] data;
        foreach (echo_hist[i])
            echo_hist[i] = '0;
        hist_pos   = 0;
        mdl_enable = 1'b0;
        mdl_delay  = DELAY_RESET;
        mdl_gain   = GAIN_RESET;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        idle_pct = 6;

        // pass-through at reset settings
        queue_sample(16'h0000);
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_sample(16'h0001);
        queue_sample(16'hFFFF);
        queue_sample(16'h5555);
        queue_sample(16'hAAAA);
        settle();

        // zero delay, unity gain: the tap is the sample itself, sums overflow
        reg_write(CFG_UNUSED, 16'hFFFF);
        reg_write(CFG_ENABLE, 16'h0001);
        reg_write(CFG_DELAY, 16'h0000);
        reg_write(CFG_GAIN, GAIN_ONE);
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_sample(16'h0001);
        queue_sample(16'hFFFF);
        queue_sample(16'h0064);
        settle();

        // one-sample delay with gain above one, which saturates
        reg_write(CFG_DELAY, 16'h0001);
        reg_write(CFG_GAIN, 16'hFFFF);
        queue_sample(16'h4E20);
        queue_sample(16'h4E20);
        queue_sample(16'h8000);
        queue_sample(16'h8000);
        queue_sample(16'h0005);
        settle();

        // longest delay, top data bit dropped, zero gain
        reg_write(CFG_DELAY, 16'hFFFF);
        reg_write(CFG_GAIN, 16'h0000);
        queue_sample(16'h0003);
        queue_sample(16'hFFFD);
        settle();

        // echo off through bit 0 only
        reg_write(CFG_ENABLE, 16'hFFFE);
        reg_write(CFG_DELAY, 16'h0002);
        reg_write(CFG_GAIN, 16'h8001);
        queue_sample(16'h1234);
        queue_sample(16'h8000);
        queue_sample(16'h7FFF);
        settle();

        for (ph = 0; ph < 8; ph++)
        begin
            case ($urandom_range(0, 3))
                0:       idle_pct = 0;
                1:       idle_pct = 2;
                2:       idle_pct = 6;
                default: idle_pct = 15;
            endcase
            // last phase runs flat out
            if (ph == 7)
                idle_pct = 0;

            data    = CFG_DATA_W'($urandom_range(0, 65535));
            data[0] = (ph == 7) || ($urandom_range(0, 4) != 0);
            reg_write(CFG_ENABLE, data);

            case ($urandom_range(0, 7))
                0:       data = 16'h0000;
                1:       data = 16'h0001;
                2:       data = 16'h0002;
                3, 4:    data = CFG_DATA_W'($urandom_range(3, 64));
                5:       data = CFG_DATA_W'($urandom_range(65, 1000));
                6:       data = CFG_DATA_W'($urandom_range(0, 65535));
                default: data = 16'h7FFF;
            endcase
            reg_write(CFG_DELAY, data);

            case ($urandom_range(0, 5))
                0:       data = 16'h0000;
                1:       data = GAIN_ONE;
                2:       data = CFG_DATA_W'($urandom_range(GAIN_ONE + 1, 65535));
                default: data = CFG_DATA_W'($urandom_range(0, GAIN_ONE));
            endcase
            reg_write(CFG_GAIN, data);

            if ($urandom_range(0, 2) == 0)
                reg_write(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 65535)));

            n_items = (ph == 7) ? 110 : 160;
            repeat (n_items)
                queue_sample(rand_sample());
            settle();
        end

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
